FILE: rtl/tmtw_pkg.sv
// Shared constants, codes and controller/datapath types for the text terminal writer.
package tmtw_pkg;

  localparam int DefaultColumns = 80;
  localparam int DefaultRows    = 25;

  localparam int CharW     = 8;
  localparam int ColourW   = 4;
  localparam int CellW     = 16;
  localparam int ColOutW   = 7;
  localparam int RowOutW   = 5;
  localparam int CfgIndexW = 1;
  localparam int CfgDataW  = 4;

  localparam logic OP_PUT   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic [CfgIndexW-1:0] REG_FOREGROUND = 1'b0;
  localparam logic [CfgIndexW-1:0] REG_BACKGROUND = 1'b1;

  localparam logic [CharW-1:0] CH_SPACE   = 8'h20;
  localparam logic [CharW-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CharW-1:0] CH_RETURN  = 8'h0D;

  localparam logic [ColourW-1:0] RESET_FOREGROUND = 4'd7;
  localparam logic [ColourW-1:0] RESET_BACKGROUND = 4'd0;

  typedef struct packed {
    logic accept;
    logic load_out;
  } tmtw_cmd_t;

  typedef struct packed {
    logic busy;
    logic out_free;
  } tmtw_status_t;

endpackage

FILE: rtl/tmtw_if.sv
// Valid/ready channel interfaces for terminal input items and cursor results.
interface tmtw_in_if;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [tmtw_pkg::CharW-1:0] char_code;

  modport source (output valid, op, char_code, input ready);
  modport sink   (input valid, op, char_code, output ready);
endinterface

interface tmtw_out_if;
  logic                        valid;
  logic                        ready;
  logic [tmtw_pkg::ColOutW-1:0] cursor_column;
  logic [tmtw_pkg::RowOutW-1:0] cursor_row;
  logic                        scrolled;

  modport source (output valid, cursor_column, cursor_row, scrolled, input ready);
  modport sink   (input valid, cursor_column, cursor_row, scrolled, output ready);
endinterface

FILE: rtl/tmtw_ctrl.sv
// Controller state machine: sequences item acceptance, store sweeps and result hand-off.
module tmtw_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  tmtw_pkg::tmtw_status_t status,
  output tmtw_pkg::tmtw_cmd_t    cmd
);

  localparam logic [1:0] S_INIT = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_WORK = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd.accept   = 1'b0;
    cmd.load_out = 1'b0;
    case (state)
      S_INIT: begin
        if (!status.busy) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_next = S_WORK;
        end
      end
      S_WORK: begin
        if (!status.busy && status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/tmtw_datapath.sv
// Datapath: cursor, colour registers, screen store with sweep engine, result register.
module tmtw_datapath #(
  parameter int Columns = tmtw_pkg::DefaultColumns,
  parameter int Rows    = tmtw_pkg::DefaultRows
) (
  input  logic                            clk,
  input  logic                            rst,
  input  tmtw_pkg::tmtw_cmd_t             cmd,
  output tmtw_pkg::tmtw_status_t          status,
  input  logic                            in_op,
  input  logic [tmtw_pkg::CharW-1:0]      in_char,
  input  logic                            cfg_we,
  input  logic [tmtw_pkg::CfgIndexW-1:0]  cfg_index,
  input  logic [tmtw_pkg::CfgDataW-1:0]   cfg_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tmtw_pkg::ColOutW-1:0]    out_column,
  output logic [tmtw_pkg::RowOutW-1:0]    out_row,
  output logic                            out_scrolled
);

  localparam int Cells  = Rows * Columns;
  localparam int AddrW  = $clog2(Cells);
  localparam int ColW   = $clog2(Columns);
  localparam int RowW   = $clog2(Rows);

  localparam logic [1:0] SW_RESET  = 2'd0;
  localparam logic [1:0] SW_FILL   = 2'd1;
  localparam logic [1:0] SW_SCROLL = 2'd2;

  localparam logic [ColW-1:0]  LastCol   = ColW'(Columns - 1);
  localparam logic [RowW-1:0]  LastRow   = RowW'(Rows - 1);
  localparam logic [AddrW-1:0] LastCell  = AddrW'(Cells - 1);
  localparam logic [AddrW-1:0] CopyLimit = AddrW'(Cells - Columns);
  localparam logic [AddrW:0]   RowStride = (AddrW + 1)'(Columns);

  localparam logic [tmtw_pkg::CellW-1:0] ResetBlank =
    {tmtw_pkg::RESET_BACKGROUND, tmtw_pkg::RESET_FOREGROUND, tmtw_pkg::CH_SPACE};

  logic [tmtw_pkg::ColourW-1:0] fg;
  logic [tmtw_pkg::ColourW-1:0] bg;
  logic [ColW-1:0]              cursor_col;
  logic [RowW-1:0]              cursor_row;
  logic                         scrolled;

  logic [ColW-1:0]              cursor_col_next;
  logic [RowW-1:0]              cursor_row_next;
  logic                         is_clear;
  logic                         is_print;
  logic                         advance_row;
  logic                         do_scroll;

  logic                         sweep_active;
  logic [AddrW-1:0]             sweep_idx;
  logic [1:0]                   sweep_mode;
  logic                         stage_valid;
  logic [AddrW-1:0]             stage_addr;
  logic                         stage_copy;
  logic [tmtw_pkg::CellW-1:0]   stage_data;

  logic                         copy_now;
  logic [AddrW-1:0]             rd_addr;
  logic [AddrW-1:0]             put_addr;
  logic [tmtw_pkg::CellW-1:0]   rd_data;
  logic [tmtw_pkg::CellW-1:0]   blank_cell;
  logic [tmtw_pkg::CellW-1:0]   mem [Cells];

  assign blank_cell = {bg, fg, tmtw_pkg::CH_SPACE};

  always_comb begin
    is_clear        = (in_op == tmtw_pkg::OP_CLEAR);
    is_print        = !is_clear && (in_char != tmtw_pkg::CH_NEWLINE)
                      && (in_char != tmtw_pkg::CH_RETURN);
    advance_row     = !is_clear && ((in_char == tmtw_pkg::CH_NEWLINE)
                      || (is_print && (cursor_col == LastCol)));
    do_scroll       = advance_row && (cursor_row == LastRow);
    cursor_col_next = '0;
    cursor_row_next = cursor_row;
    if (is_clear) begin
      cursor_row_next = '0;
    end else begin
      if (is_print && (cursor_col != LastCol)) begin
        cursor_col_next = cursor_col + 1'b1;
      end
      if (advance_row && !do_scroll) begin
        cursor_row_next = cursor_row + 1'b1;
      end
    end
  end

  // Config registers, cursor and scroll flag
  always_ff @(posedge clk) begin
    if (rst) begin
      fg         <= tmtw_pkg::RESET_FOREGROUND;
      bg         <= tmtw_pkg::RESET_BACKGROUND;
      cursor_col <= '0;
      cursor_row <= '0;
      scrolled   <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index == tmtw_pkg::REG_FOREGROUND)) begin
        fg <= cfg_data;
      end
      if (cfg_we && (cfg_index == tmtw_pkg::REG_BACKGROUND)) begin
        bg <= cfg_data;
      end
      if (cmd.accept) begin
        cursor_col <= cursor_col_next;
        cursor_row <= cursor_row_next;
        scrolled   <= do_scroll;
      end
    end
  end

  // Sweep engine: one cell per cycle, through a registered write stage
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_active <= 1'b1;
      sweep_idx    <= '0;
      sweep_mode   <= SW_RESET;
      stage_valid  <= 1'b0;
    end else begin
      stage_valid <= sweep_active;
      if (cmd.accept && (is_clear || do_scroll)) begin
        sweep_active <= 1'b1;
        sweep_idx    <= '0;
        sweep_mode   <= is_clear ? SW_FILL : SW_SCROLL;
      end else if (sweep_active) begin
        sweep_idx <= sweep_idx + 1'b1;
        if (sweep_idx == LastCell) begin
          sweep_active <= 1'b0;
        end
      end
    end
  end

  assign copy_now = (sweep_mode == SW_SCROLL) && (sweep_idx < CopyLimit);
  assign rd_addr  = copy_now ? AddrW'({1'b0, sweep_idx} + RowStride) : sweep_idx;
  assign put_addr = AddrW'(32'(cursor_row) * 32'(Columns) + 32'(cursor_col));

  always_ff @(posedge clk) begin
    stage_addr <= sweep_idx;
    stage_copy <= copy_now;
    stage_data <= (sweep_mode == SW_RESET) ? ResetBlank : blank_cell;
  end

  always_ff @(posedge clk) begin
    if (stage_valid) begin
      mem[stage_addr] <= stage_copy ? rd_data : stage_data;
    end else if (cmd.accept && is_print) begin
      mem[put_addr] <= {bg, fg, in_char};
    end
    rd_data <= mem[rd_addr];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_column   <= tmtw_pkg::ColOutW'(cursor_col);
      out_row      <= tmtw_pkg::RowOutW'(cursor_row);
      out_scrolled <= scrolled;
    end
  end

  assign status.busy     = sweep_active || stage_valid;
  assign status.out_free = !out_valid || out_ready;

`ifndef SYNTHESIS
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    cursor_col <= LastCol)
    else $error("cursor column out of range");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    cursor_row <= LastRow)
    else $error("cursor row out of range");

  a_accept_not_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |-> !sweep_active && !stage_valid)
    else $error("item accepted during store sweep");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready) && !status.busy)
    else $error("result loaded over a pending transaction");

  a_scroll_row: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && do_scroll) |=> (cursor_row == LastRow) && sweep_active)
    else $error("scroll did not hold cursor on last row");
`endif

endmodule

FILE: rtl/text_mode_terminal_writer_unit.sv
// Top level of the character-cell text terminal writer.
// Usage:
//   in_ch  carries one item per transaction: op (put or clear) and char_code.
//   out_ch returns one result per item: cursor_column, cursor_row, scrolled.
//   cfg_we/cfg_index/cfg_data write foreground (index 0) and background
//   (index 1) colours; write only while no item is in flight.
// Timing:
//   A put of a printable byte, newline or carriage return without scroll goes
//   from acceptance through the work state to the result register once out_ch is free.
//   A scroll or a clear sweeps the Rows x Columns cell store, one cell per
//   cycle through a registered read and a write stage.
//   The next item is accepted as soon as the result is registered, even
//   while that result still waits on out_ch.
// Reset:
//   rst clears the cursor, restores the reset colours and runs a clearing
//   pass over the cell store; in_ch.ready rises in the cycle after it ends.
// Stall:
//   If out_ch.ready is low with a result pending, the next finished result
//   is held inside and in_ch.ready stays low until the output frees.
module text_mode_terminal_writer_unit #(
  parameter int Columns = tmtw_pkg::DefaultColumns,
  parameter int Rows    = tmtw_pkg::DefaultRows
) (
  input  logic                           clk,
  input  logic                           rst,
  tmtw_in_if.sink                        in_ch,
  tmtw_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [tmtw_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [tmtw_pkg::CfgDataW-1:0]  cfg_data
);

  tmtw_pkg::tmtw_cmd_t    cmd;
  tmtw_pkg::tmtw_status_t status;

  tmtw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  tmtw_datapath #(
    .Columns (Columns),
    .Rows    (Rows)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .in_op        (in_ch.op),
    .in_char      (in_ch.char_code),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_column   (out_ch.cursor_column),
    .out_row      (out_ch.cursor_row),
    .out_scrolled (out_ch.scrolled)
  );

endmodule

FILE: tb/sv/tb_text_mode_terminal_writer_unit.sv
// Self-checking testbench: cursor and scroll prediction for the text terminal writer.
module tb_text_mode_terminal_writer_unit;
  import tmtw_pkg::*;

  localparam int COLS         = DefaultColumns;
  localparam int ROWS         = DefaultRows;
  localparam int CELLS        = COLS * ROWS;
  localparam int SWEEP_CYCLES = CELLS + 3;
  localparam int STALL_LIMIT  = 25000;
  localparam int CHUNKS       = 12;
  localparam int CHUNK_ITEMS  = 112;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [ColOutW-1:0] col;
    logic [RowOutW-1:0] row;
    logic               scrolled;
  } cursor_t;

  class cursor_tracker;
    logic [CellW-1:0]   cells [CELLS];
    int                 col;
    int                 line;
    logic [ColourW-1:0] fg;
    logic [ColourW-1:0] bg;
    cursor_t            expected_q[$];
    int                 fail_count;
    int                 result_count;
    int                 scroll_count;
    int                 clear_count;

    function new();
      fg = RESET_FOREGROUND;
      bg = RESET_BACKGROUND;
      col = 0;
      line = 0;
      blank_from(0);
    endfunction

    function logic [CellW-1:0] make_cell(logic [CharW-1:0] ch);
      return {bg, fg, ch};
    endfunction

    function void blank_from(int first);
      for (int i = first; i < CELLS; i++) cells[i] = make_cell(CH_SPACE);
    endfunction

    function void set_colour(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] data);
      if (idx == REG_FOREGROUND) fg = data[ColourW-1:0];
      else bg = data[ColourW-1:0];
    endfunction

    function void flag_failure(string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) $display("ERROR at %0t: %s", $realtime, msg);
    endfunction

    function void note_item(logic op, logic [CharW-1:0] ch);
      cursor_t res;
      res.scrolled = 1'b0;
      if (op == OP_CLEAR) begin
        blank_from(0);
        col = 0;
        line = 0;
        clear_count++;
      end else begin
        if (ch == CH_NEWLINE) begin
          col = 0;
          line++;
        end else if (ch == CH_RETURN) begin
          col = 0;
        end else begin
          cells[line * COLS + col] = make_cell(ch);
          col++;
          if (col >= COLS) begin
            col = 0;
            line++;
          end
        end
        if (line >= ROWS) begin
          for (int i = 0; i < CELLS - COLS; i++) cells[i] = cells[i + COLS];
          blank_from(CELLS - COLS);
          line = ROWS - 1;
          res.scrolled = 1'b1;
          scroll_count++;
        end
      end
      res.col = ColOutW'(col);
      res.row = RowOutW'(line);
      expected_q.push_back(res);
    endfunction

    function void check_result(cursor_t got);
      cursor_t want;
      result_count++;
      if (expected_q.size() == 0) begin
        flag_failure($sformatf("result col %0d row %0d scrolled %0d with nothing expected",
                               got.col, got.row, got.scrolled));
        return;
      end
      want = expected_q.pop_front();
      if (got.col != want.col || got.row != want.row || got.scrolled != want.scrolled)
        flag_failure($sformatf("expected col %0d row %0d scrolled %0d, got col %0d row %0d scrolled %0d",
                               want.col, want.row, want.scrolled,
                               got.col, got.row, got.scrolled));
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CfgIndexW-1:0] cfg_index;
  logic [CfgDataW-1:0]  cfg_data;
  int                   src_idle_pct;
  int                   snk_idle_pct;
  int                   item_count;
  int                   colour_writes;
  cursor_tracker        tracker;

  logic [CharW:0] script [20] = '{
    {OP_PUT, 8'h48}, {OP_PUT, 8'h00}, {OP_PUT, 8'hFF}, {OP_PUT, 8'h7F},
    {OP_PUT, 8'h80}, {OP_PUT, CH_SPACE}, {OP_PUT, CH_RETURN}, {OP_PUT, CH_RETURN},
    {OP_PUT, CH_NEWLINE}, {OP_PUT, 8'h01}, {OP_PUT, 8'hFE}, {OP_PUT, CH_NEWLINE},
    {OP_CLEAR, 8'hFF}, {OP_PUT, CH_NEWLINE}, {OP_CLEAR, CH_NEWLINE}, {OP_CLEAR, 8'h00},
    {OP_PUT, 8'h55}, {OP_PUT, 8'hAA}, {OP_CLEAR, CH_RETURN}, {OP_PUT, CH_RETURN}
  };

  tmtw_in_if  in_ch();
  tmtw_out_if out_ch();

  text_mode_terminal_writer_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_ch.valid && out_ch.ready)
        tracker.check_result({out_ch.cursor_column, out_ch.cursor_row, out_ch.scrolled});
      if (in_ch.valid && in_ch.ready) tracker.note_item(in_ch.op, in_ch.char_code);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [CharW-1:0] printable_byte();
    logic [CharW-1:0] ch;
    do ch = CharW'($urandom); while (ch == CH_NEWLINE || ch == CH_RETURN);
    return ch;
  endfunction

  task automatic send_item(input logic op, input logic [CharW-1:0] ch);
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.op        = op;
    in_ch.char_code = ch;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    item_count++;
  endtask

  task automatic send_text(input int n);
    repeat (n) send_item(OP_PUT, printable_byte());
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (tracker.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_colour(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    tracker.set_colour(idx, data);
    colour_writes++;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_burst();
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 50) begin
      send_text($urandom_range(0, 30));
      send_item(OP_PUT, CH_NEWLINE);
    end else if (kind < 70) begin
      send_text($urandom_range(70, 170));
    end else if (kind < 82) begin
      send_text($urandom_range(0, 40));
      send_item(OP_PUT, CH_RETURN);
      send_text($urandom_range(0, 20));
    end else if (kind < 92) begin
      repeat ($urandom_range(1, 4)) send_item(OP_PUT, CH_NEWLINE);
    end else if (kind < 96) begin
      send_item(OP_CLEAR, CharW'($urandom));
    end else begin
      repeat ($urandom_range(1, 10)) send_item(1'($urandom), CharW'($urandom));
    end
  endtask

  initial begin
    int start;
    logic [ColourW-1:0] fg_val;
    logic [ColourW-1:0] bg_val;
    tracker         = new();
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = REG_FOREGROUND;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.op        = OP_PUT;
    in_ch.char_code = '0;
    src_idle_pct    = 38;
    snk_idle_pct    = 83;
    item_count      = 0;
    colour_writes   = 0;
    repeat (4) @(negedge clk);
    rst = 1'b0;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);

    foreach (script[i]) send_item(script[i][CharW], script[i][CharW-1:0]);
    drain_results();

    for (int k = 0; k < CHUNKS; k++) begin
      src_idle_pct = (k < 4) ? 38 : (k < 8) ? 83 : 0;
      snk_idle_pct = (k < 4) ? 83 : (k < 8) ? 38 : 0;
      case (k)
        0: begin fg_val = 4'h0; bg_val = 4'h0; end
        1: begin fg_val = 4'hF; bg_val = 4'hF; end
        2: begin fg_val = 4'hF; bg_val = 4'h0; end
        3: begin fg_val = 4'h0; bg_val = 4'hF; end
        default: begin
          fg_val = ColourW'($urandom);
          bg_val = ColourW'($urandom);
        end
      endcase
      write_colour(REG_FOREGROUND, fg_val);
      write_colour(REG_BACKGROUND, bg_val);
      start = item_count;
      while (item_count - start < CHUNK_ITEMS) send_burst();
      drain_results();
    end

    repeat (SWEEP_CYCLES + 16) @(posedge clk);
    if (tracker.expected_q.size() != 0)
      tracker.flag_failure($sformatf("%0d results never arrived", tracker.expected_q.size()));

    $display("Run covered %0d items and %0d results, with %0d scrolls and %0d clears,",
             item_count, tracker.result_count, tracker.scroll_count, tracker.clear_count);
    $display("under %0d colour writes and three pacing modes; %0d failures",
             colour_writes, tracker.fail_count);
    if (tracker.fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/tmtw_pkg.sv
rtl/tmtw_if.sv
rtl/tmtw_ctrl.sv
rtl/tmtw_datapath.sv
rtl/text_mode_terminal_writer_unit.sv
tb/sv/tb_text_mode_terminal_writer_unit.sv
